/* rtl/assert_macros.svh */
// assertion macros used by the detector top level
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/epp_pkg.sv */
// constants, register indexes and inter-module structs of the palindrome prefix detector
// no dependencies
package epp_pkg;

  localparam int MAX_LEN   = 1024;
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int SYM_W     = 20;
  localparam int HASH_W    = 24;
  localparam int MOD_W     = HASH_W + 1;
  localparam int LEN_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HASH_BASE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HASH_MODULUS = CFG_IDX_W'(1);

  localparam logic [HASH_W-1:0] BASE_RESET = HASH_W'(999983);
  localparam logic [HASH_W-1:0] MOD_RESET  = HASH_W'(10004983);

  localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(MAX_LEN);
  localparam logic [LEN_W-1:0] LEN_FULL   = LEN_W'(MAX_LEN);

  // operations of the shared modular unit
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_ADD = 1'b1;

  typedef struct packed {
    logic              start;
    logic              op;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } mod_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [HASH_W-1:0] value;
  } mod_rsp_t;

  typedef struct packed {
    logic             en;
    logic [ADDR_W-1:0] addr;
    logic [SYM_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] length;
  } walk_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic match;
  } walk_rsp_t;

endpackage

/* rtl/epp_ifs.sv */
// valid/ready channel interfaces: symbol items, result items, config writes
// depends on epp_pkg
interface epp_item_if
  import epp_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface epp_result_if
  import epp_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] prefix_length;
  logic             even_palindrome;
  logic             overflow;
  logic             end_of_sequence;

  modport source (output valid, output prefix_length, output even_palindrome,
                  output overflow, output end_of_sequence, input ready);
  modport sink   (input valid, input prefix_length, input even_palindrome,
                  input overflow, input end_of_sequence, output ready);
endinterface

interface epp_cfg_if
  import epp_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [HASH_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/epp_modunit.sv */
// shared modular arithmetic unit: a*b mod q one bit of b per cycle, or a+b mod q
// depends on epp_pkg
module epp_modunit
  import epp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [MOD_W-1:0] modulus,
  input  mod_req_t         req,
  output mod_rsp_t         rsp
);

  localparam int STEP_W = $clog2(HASH_W + 1);

  logic              busy;
  logic              done;
  logic              op;
  logic [HASH_W-1:0] opa;
  logic [HASH_W-1:0] opb;
  logic [HASH_W-1:0] acc;
  logic [STEP_W-1:0] steps;

  logic [MOD_W:0] q_ext;
  logic [MOD_W:0] dbl;
  logic [MOD_W:0] dbl_red;
  logic [MOD_W:0] addend;
  logic [MOD_W:0] sum;
  logic [MOD_W:0] sum_red;

  // acc and opa stay below q, so each sum needs one conditional subtract
  always_comb begin
    q_ext = {1'b0, modulus};
    dbl   = {1'b0, acc, 1'b0};
    if (dbl >= q_ext) begin
      dbl_red = dbl - q_ext;
    end else begin
      dbl_red = dbl;
    end
    addend = opb[HASH_W-1] ? {2'b00, opa} : '0;
    if (op == OP_ADD) begin
      dbl_red = {2'b00, opa};
      addend  = {2'b00, opb};
    end
    sum = dbl_red + addend;
    if (sum >= q_ext) begin
      sum_red = sum - q_ext;
    end else begin
      sum_red = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        op    <= req.op;
        opa   <= req.a;
        opb   <= req.b;
        acc   <= '0;
        steps <= (req.op == OP_ADD) ? STEP_W'(1) : STEP_W'(HASH_W);
      end else if (busy) begin
        acc   <= sum_red[HASH_W-1:0];
        opb   <= {opb[HASH_W-2:0], 1'b0};
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{busy: busy, done: done, value: acc};

endmodule

/* rtl/epp_store.sv */
// symbol memory with a pairwise walk that compares the two halves of a prefix
// depends on epp_pkg
module epp_store
  import epp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  store_wr_t wr,
  input  walk_req_t walk_req,
  output walk_rsp_t walk_rsp
);

  logic [SYM_W-1:0]  mem [MAX_LEN];
  logic [SYM_W-1:0]  rd_lo;
  logic [SYM_W-1:0]  rd_hi;
  logic [ADDR_W-1:0] lo;
  logic [ADDR_W-1:0] hi;
  logic [CNT_W-1:0]  remaining;
  logic [CNT_W-1:0]  last_idx;
  logic              busy;
  logic              pend;
  logic              mismatch;
  logic              done;

  assign last_idx = walk_req.length - 1'b1;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (busy && remaining != '0) begin
      rd_lo <= mem[lo];
      rd_hi <= mem[hi];
    end
  end

  // reads issue one pair per cycle, each pair is compared in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (walk_req.start) begin
        busy      <= 1'b1;
        pend      <= 1'b0;
        mismatch  <= 1'b0;
        lo        <= '0;
        hi        <= last_idx[ADDR_W-1:0];
        remaining <= walk_req.length >> 1;
      end else if (busy) begin
        if (pend && rd_lo != rd_hi) begin
          mismatch <= 1'b1;
        end
        if (remaining != '0) begin
          lo        <= lo + 1'b1;
          hi        <= hi - 1'b1;
          remaining <= remaining - 1'b1;
          pend      <= 1'b1;
        end else begin
          pend <= 1'b0;
          if (!pend) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign walk_rsp = '{busy: busy, done: done, match: !mismatch};

endmodule

/* rtl/even_palindrome_prefix_detect.sv */
// palindrome prefix detector top level: sequencer, hash state, config and result register
// depends on epp_pkg, epp_ifs, epp_modunit, epp_store, assert_macros.svh
// per stored symbol: three or four modular multiplies and two modular adds, three reductions
//   first after a modulus write, the halves walk for an even prefix with equal hashes
// one symbol at a time, overflow straight to the result; a held result stalls the next in ST_DONE
// reset: synchronous, restores register defaults and clears count and hashes; the memory
//   is not cleared
`include "assert_macros.svh"

module even_palindrome_prefix_detect
  import epp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  epp_item_if.sink      item,
  epp_result_if.source  result,
  epp_cfg_if.sink       cfg
);

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RED_F = 4'd1;  // reduce forward hash after modulus change
  localparam logic [3:0] ST_RED_R = 4'd2;  // reduce reverse hash
  localparam logic [3:0] ST_RED_P = 4'd3;  // reduce base power
  localparam logic [3:0] ST_SYM   = 4'd4;  // symbol mod q
  localparam logic [3:0] ST_FMUL  = 4'd5;  // forward * base
  localparam logic [3:0] ST_FADD  = 4'd6;  // + symbol
  localparam logic [3:0] ST_RMUL  = 4'd7;  // symbol * base power
  localparam logic [3:0] ST_RADD  = 4'd8;  // reverse + that product
  localparam logic [3:0] ST_PMUL  = 4'd9;  // base power * base
  localparam logic [3:0] ST_WALK  = 4'd10; // exact halves check
  localparam logic [3:0] ST_DONE  = 4'd11; // load result register

  logic [3:0]        state;
  logic              issued;

  // configuration and hash state
  logic [HASH_W-1:0] hash_base;
  logic [HASH_W-1:0] hash_modulus;
  logic              dirty;
  logic [CNT_W-1:0]  count;
  logic [HASH_W-1:0] forward;
  logic [HASH_W-1:0] reverse;
  logic [HASH_W-1:0] bpow;
  logic [HASH_W-1:0] s_val;
  logic [HASH_W-1:0] prod;

  // current item
  logic [SYM_W-1:0]  sym_r;
  logic              last_r;
  logic              ovf_r;
  logic              pal_r;
  logic [LEN_W-1:0]  len_r;

  // result register
  logic              out_valid;
  logic [LEN_W-1:0]  out_len;
  logic              out_pal;
  logic              out_ovf;
  logic              out_eos;

  logic [MOD_W-1:0]  q;
  logic [HASH_W-1:0] one_mod;
  logic              sym_direct;
  logic              arith_state;
  logic              item_fire;
  logic              cfg_fire;
  logic              out_free;

  mod_req_t  mod_req;
  mod_rsp_t  mod_rsp;
  store_wr_t store_wr;
  walk_req_t walk_req;
  walk_rsp_t walk_rsp;

  // a zero modulus register means 2^24
  assign q          = (hash_modulus == '0) ? {1'b1, {HASH_W{1'b0}}} : {1'b0, hash_modulus};
  assign one_mod    = (q == MOD_W'(1)) ? '0 : HASH_W'(1);
  // every symbol is already below a modulus that reaches past the symbol range
  assign sym_direct = (q[MOD_W-1:SYM_W] != '0);

  assign item.ready = !rst && (state == ST_IDLE);
  assign cfg.ready  = !rst;
  assign item_fire  = item.valid && item.ready;
  assign cfg_fire   = cfg.valid && cfg.ready;
  assign out_free   = !out_valid || result.ready;

  assign result.valid           = out_valid;
  assign result.prefix_length   = out_len;
  assign result.even_palindrome = out_pal;
  assign result.overflow        = out_ovf;
  assign result.end_of_sequence = out_eos;

  assign arith_state = (state == ST_RED_F) || (state == ST_RED_R) || (state == ST_RED_P) ||
                       (state == ST_SYM) || (state == ST_FMUL) || (state == ST_FADD) ||
                       (state == ST_RMUL) || (state == ST_RADD) || (state == ST_PMUL);

  // operand selection for the shared unit
  always_comb begin
    mod_req.start = arith_state && !issued && !((state == ST_SYM) && sym_direct);
    mod_req.op    = OP_MUL;
    mod_req.a     = one_mod;
    mod_req.b     = forward;
    unique case (state)
      ST_RED_F: mod_req.b = forward;
      ST_RED_R: mod_req.b = reverse;
      ST_RED_P: mod_req.b = bpow;
      ST_SYM:   mod_req.b = {{(HASH_W - SYM_W){1'b0}}, sym_r};
      ST_FMUL: begin
        mod_req.a = forward;
        mod_req.b = hash_base;
      end
      ST_FADD: begin
        mod_req.op = OP_ADD;
        mod_req.a  = prod;
        mod_req.b  = s_val;
      end
      ST_RMUL: begin
        mod_req.a = bpow;
        mod_req.b = s_val;
      end
      ST_RADD: begin
        mod_req.op = OP_ADD;
        mod_req.a  = reverse;
        mod_req.b  = prod;
      end
      ST_PMUL: begin
        mod_req.a = bpow;
        mod_req.b = hash_base;
      end
      default: begin
        mod_req.a = one_mod;
      end
    endcase
  end

  // symbols go into the store on the transfer itself, before any walk reads them
  assign store_wr = '{en: item_fire && (count < COUNT_FULL),
                      addr: count[ADDR_W-1:0],
                      data: item.symbol};

  assign walk_req = '{start: (state == ST_WALK) && !issued, length: count};

  epp_modunit u_modunit (
    .clk     (clk),
    .rst     (rst),
    .modulus (q),
    .req     (mod_req),
    .rsp     (mod_rsp)
  );

  epp_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (store_wr),
    .walk_req (walk_req),
    .walk_rsp (walk_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      issued       <= 1'b0;
      hash_base    <= BASE_RESET;
      hash_modulus <= MOD_RESET;
      dirty        <= 1'b0;
      count        <= '0;
      forward      <= '0;
      reverse      <= '0;
      bpow         <= HASH_W'(1);
      out_valid    <= 1'b0;
    end else begin
      // the source must send config transfers only while idle; the block itself does not enforce it
      if (cfg_fire) begin
        if (cfg.index == REG_HASH_BASE) begin
          hash_base <= cfg.data;
        end else if (cfg.index == REG_HASH_MODULUS) begin
          hash_modulus <= cfg.data;
          dirty        <= 1'b1;
        end
      end

      // in ST_DONE the result load below decides the valid flag
      if (out_valid && result.ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      if (mod_req.start || walk_req.start) begin
        issued <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (item_fire) begin
            sym_r  <= item.symbol;
            last_r <= item.last;
            pal_r  <= 1'b0;
            if (count >= COUNT_FULL) begin
              ovf_r <= 1'b1;
              len_r <= LEN_FULL;
              state <= ST_DONE;
            end else begin
              ovf_r <= 1'b0;
              count <= count + 1'b1;
              len_r <= LEN_W'(count + 1'b1);
              state <= dirty ? ST_RED_F : ST_SYM;
            end
          end
        end
        ST_RED_F: begin
          if (mod_rsp.done) begin
            forward <= mod_rsp.value;
            issued  <= 1'b0;
            state   <= ST_RED_R;
          end
        end
        ST_RED_R: begin
          if (mod_rsp.done) begin
            reverse <= mod_rsp.value;
            issued  <= 1'b0;
            state   <= ST_RED_P;
          end
        end
        ST_RED_P: begin
          if (mod_rsp.done) begin
            bpow   <= mod_rsp.value;
            dirty  <= 1'b0;
            issued <= 1'b0;
            state  <= ST_SYM;
          end
        end
        ST_SYM: begin
          if (sym_direct) begin
            s_val <= {{(HASH_W - SYM_W){1'b0}}, sym_r};
            state <= ST_FMUL;
          end else if (mod_rsp.done) begin
            s_val  <= mod_rsp.value;
            issued <= 1'b0;
            state  <= ST_FMUL;
          end
        end
        ST_FMUL: begin
          if (mod_rsp.done) begin
            prod   <= mod_rsp.value;
            issued <= 1'b0;
            state  <= ST_FADD;
          end
        end
        ST_FADD: begin
          if (mod_rsp.done) begin
            forward <= mod_rsp.value;
            issued  <= 1'b0;
            state   <= ST_RMUL;
          end
        end
        ST_RMUL: begin
          if (mod_rsp.done) begin
            prod   <= mod_rsp.value;
            issued <= 1'b0;
            state  <= ST_RADD;
          end
        end
        ST_RADD: begin
          if (mod_rsp.done) begin
            reverse <= mod_rsp.value;
            issued  <= 1'b0;
            state   <= ST_PMUL;
          end
        end
        ST_PMUL: begin
          if (mod_rsp.done) begin
            bpow   <= mod_rsp.value;
            issued <= 1'b0;
            // only an even prefix with agreeing hashes needs the exact check
            if (!count[0] && forward == reverse) begin
              state <= ST_WALK;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_WALK: begin
          if (walk_rsp.done) begin
            pal_r  <= walk_rsp.match;
            issued <= 1'b0;
            state  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_len   <= len_r;
            out_pal   <= pal_r;
            out_ovf   <= ovf_r;
            out_eos   <= last_r;
            // end of sequence: back to the empty prefix under the current modulus
            if (last_r) begin
              count   <= '0;
              forward <= '0;
              reverse <= '0;
              bpow    <= one_mod;
              dirty   <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `ASSERT_NEXT(a_busy_after_transfer, clk, rst, item_fire, !item.ready)
  `ASSERT_IMPLIES(a_unit_free_on_start, clk, rst, mod_req.start, !mod_rsp.busy)
  `ASSERT_IMPLIES(a_walk_needs_candidate, clk, rst, walk_req.start,
                  !walk_rsp.busy && !count[0] && forward == reverse)
  `ASSERT_IMPLIES(a_no_write_when_full, clk, rst, item_fire && count >= COUNT_FULL,
                  !store_wr.en)
  `ASSERT_IMPLIES(a_overflow_not_palindrome, clk, rst, out_valid && out_ovf, !out_pal)

endmodule

/* bench/epp_checker.sv */
// checker for the palindrome prefix detector: mirrors the hash state and compares every result
// depends on epp_pkg and the channel interfaces of epp_ifs
`timescale 1ns / 100ps

module epp_checker
  import epp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  epp_item_if   item_ch,
  epp_result_if result_ch,
  epp_cfg_if    cfg_ch,
  output int    mismatch_count,
  output int    results_due
);

  typedef struct packed {
    logic [LEN_W-1:0] prefix_length;
    logic             even_palindrome;
    logic             overflow;
    logic             end_of_sequence;
  } prefix_flags_t;

  prefix_flags_t flags_due[$];
  prefix_flags_t want;
  prefix_flags_t got;

  logic [SYM_W-1:0]  kept_symbols [MAX_LEN];
  logic [CNT_W-1:0]  kept_count;
  logic [HASH_W-1:0] fwd_hash;
  logic [HASH_W-1:0] rev_hash;
  logic [HASH_W-1:0] power_term;
  logic [HASH_W-1:0] base_reg;
  logic [HASH_W-1:0] modulus_reg;

  // a zero modulus stands for 2^24
  function automatic longint unsigned active_modulus();
    return (modulus_reg == '0) ? (64'd1 << HASH_W) : 64'(modulus_reg);
  endfunction

  function automatic void restart_sequence();
    kept_count = '0;
    fwd_hash   = '0;
    rev_hash   = '0;
    power_term = HASH_W'(64'd1 % active_modulus());
  endfunction

  function automatic prefix_flags_t predict_flags(input logic [SYM_W-1:0] sym,
                                                  input logic lst);
    prefix_flags_t   p;
    longint unsigned q;
    longint unsigned s;
    int              n;
    logic            mirror;
    q = active_modulus();
    p = '0;
    p.end_of_sequence = lst;
    if (kept_count >= COUNT_FULL) begin
      p.overflow      = 1'b1;
      p.prefix_length = LEN_FULL;
    end else begin
      s = 64'(sym) % q;
      kept_symbols[kept_count[ADDR_W-1:0]] = sym;
      kept_count = kept_count + 1'b1;
      fwd_hash   = HASH_W'((64'(fwd_hash) * 64'(base_reg) % q + s) % q);
      rev_hash   = HASH_W'((64'(rev_hash) + s * 64'(power_term) % q) % q);
      power_term = HASH_W'(64'(power_term) * 64'(base_reg) % q);
      n = int'(kept_count);
      p.prefix_length = LEN_W'(n);
      // equal hashes only open the exact walk over both halves
      if (n % 2 == 0 && fwd_hash == rev_hash) begin
        mirror = 1'b1;
        for (int k = 0; k < n / 2; k++)
          if (kept_symbols[k] != kept_symbols[n - 1 - k]) mirror = 1'b0;
        p.even_palindrome = mirror;
      end
    end
    if (lst) restart_sequence();
    return p;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      base_reg       = BASE_RESET;
      modulus_reg    = MOD_RESET;
      restart_sequence();
      flags_due.delete();
      mismatch_count = 0;
    end else begin
      // a result transfer belongs to an older item than one taken at the same edge
      if (result_ch.valid && result_ch.ready) begin
        got.prefix_length   = result_ch.prefix_length;
        got.even_palindrome = result_ch.even_palindrome;
        got.overflow        = result_ch.overflow;
        got.end_of_sequence = result_ch.end_of_sequence;
        if (flags_due.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: len %0d pal %0b ovf %0b eos %0b",
                     got.prefix_length, got.even_palindrome, got.overflow,
                     got.end_of_sequence);
          mismatch_count++;
        end else begin
          want = flags_due.pop_front();
          if (got != want) begin
            if (mismatch_count < 10)
              $display("result mismatch: expected len %0d pal %0b ovf %0b eos %0b, %s",
                       want.prefix_length, want.even_palindrome, want.overflow,
                       want.end_of_sequence,
                       $sformatf("got len %0d pal %0b ovf %0b eos %0b",
                                 got.prefix_length, got.even_palindrome,
                                 got.overflow, got.end_of_sequence));
            mismatch_count++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_HASH_BASE) base_reg = cfg_ch.data;
        else if (cfg_ch.index == REG_HASH_MODULUS) modulus_reg = cfg_ch.data;
      end
      if (item_ch.valid && item_ch.ready)
        flags_due.push_back(predict_flags(item_ch.symbol, item_ch.last));
    end
    results_due <= flags_due.size();
  end

endmodule

/* bench/testbench.sv */
// top of the palindrome prefix detector bench: clock, reset, stimulus, sink and verdict
// depends on epp_pkg, epp_ifs, the detector itself and epp_checker
`timescale 1ns / 100ps

module testbench
  import epp_pkg::*;
;

  localparam int RANDOM_ITEMS_PER_PHASE = 85;
  localparam int HOLD_CYCLES            = 1500;
  localparam int WATCHDOG_LIMIT         = 20000;
  localparam int DRAIN_CYCLES           = 150;
  // index with no register behind it, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(3);

  logic clk = 1'b0;
  logic rst;
  bit   no_idle;       // both sides run back to back while set
  bit   hold_off_req;  // asks the sink for one long stall
  int   mismatch_count;
  int   results_due;

  epp_item_if   item_ch ();
  epp_result_if result_ch ();
  epp_cfg_if    cfg_ch ();

  always #5 clk = ~clk;

  even_palindrome_prefix_detect u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  epp_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .item_ch        (item_ch),
    .result_ch      (result_ch),
    .cfg_ch         (cfg_ch),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  // mostly no gap, often a short one, now and then a long one
  function automatic int idle_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 200);
  endfunction

  // narrow alphabet makes inner palindromes and hash matches common
  function automatic logic [SYM_W-1:0] pick_symbol(input bit narrow);
    if (narrow) return SYM_W'($urandom_range(0, 2));
    case ($urandom_range(0, 3))
      0:       return {SYM_W{1'b1}} - SYM_W'($urandom_range(0, 2));
      1:       return SYM_W'($urandom_range(0, 3));
      default: return SYM_W'($urandom);
    endcase
  endfunction

  // one item transfer; valid stays high when no gap follows
  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic lst);
    int gap;
    item_ch.valid  <= 1'b1;
    item_ch.symbol <= sym;
    item_ch.last   <= lst;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    gap = idle_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid, then hold until every predicted result has been taken
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HASH_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // registers change only with the block idle between sequences
  task automatic configure(input logic [HASH_W-1:0] base, input logic [HASH_W-1:0] modulus);
    wait_drained();
    write_reg(REG_HASH_BASE, base);
    write_reg(REG_HASH_MODULUS, modulus);
  endtask

  // mostly mirrored runs, some with a broken symbol or a tail, the rest noise
  task automatic random_sequence(output int count);
    logic [SYM_W-1:0] run[$];
    int               shape;
    int               half;
    int               pos;
    bit               narrow;
    shape  = $urandom_range(0, 9);
    narrow = $urandom_range(0, 1);
    half   = $urandom_range(1, 10);
    for (int i = 0; i < half; i++) run.push_back(pick_symbol(narrow));
    if (shape < 7) begin
      for (int i = half - 1; i >= 0; i--) run.push_back(run[i]);
      if (shape == 5) begin
        pos = $urandom_range(0, run.size() - 1);
        run[pos] = run[pos] ^ (SYM_W'(1) << $urandom_range(0, SYM_W - 1));
      end
      if (shape == 6) repeat ($urandom_range(1, 3)) run.push_back(pick_symbol(narrow));
    end
    foreach (run[i]) send_symbol(run[i], i == run.size() - 1);
    count = run.size();
  endtask

  // stimulus and verdict
  initial begin : stimulus
    logic [SYM_W-1:0] long_run[$];
    int               sent;
    int               n;
    rst           <= 1'b1;
    item_ch.valid  <= 1'b0;
    item_ch.symbol <= '0;
    item_ch.last   <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= '0;
    cfg_ch.data    <= '0;
    no_idle        <= 1'b0;
    hold_off_req   <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: shortest even palindrome, extreme symbols, odd and single runs
    send_symbol(20'h00000, 1'b0);
    send_symbol(20'h00000, 1'b1);
    send_symbol(20'hFFFFF, 1'b0);
    send_symbol(20'h00001, 1'b0);
    send_symbol(20'h00001, 1'b0);
    send_symbol(20'hFFFFF, 1'b1);
    send_symbol(20'h00005, 1'b0);
    send_symbol(20'h00006, 1'b0);
    send_symbol(20'h00005, 1'b1);
    send_symbol(20'h00007, 1'b1);

    // zero modulus counts as 2^24, largest base
    configure(24'hFFFFFF, 24'd0);
    send_symbol(20'hFFFFF, 1'b0);
    send_symbol(20'hFFFFF, 1'b1);

    // modulus 2: symbols above it fold to the same hash, the walk must reject 2,4
    configure(24'd1, 24'd2);
    send_symbol(20'h00002, 1'b0);
    send_symbol(20'h00004, 1'b0);
    send_symbol(20'h00004, 1'b0);
    send_symbol(20'h00002, 1'b1);

    // modulus 1 and base 0: every hash is zero, only the walk decides
    configure(24'd0, 24'd1);
    send_symbol(20'h00009, 1'b0);
    send_symbol(20'h00009, 1'b0);
    send_symbol(20'h00001, 1'b0);
    send_symbol(20'h00009, 1'b1);
    wait_drained();
    write_reg(REG_UNMAPPED, 24'h5A5A5A);

    // random phases over several settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       configure(BASE_RESET, MOD_RESET);
        1:       configure(24'd1, 24'hFFFFFF);
        2:       configure(24'hFFFFFF, 24'hFFFFFF);
        3:       configure(HASH_W'($urandom_range(1, 24'hFFFFFF)),
                           HASH_W'($urandom_range(2, 24'hFFFFFF)));
        4:       configure(24'hFFFFFF, 24'd0);
        default: configure(24'd2, 24'd3);
      endcase
      no_idle <= (phase == 4);
      // the sink stalls for a long stretch while the source keeps offering items
      if (phase == 2) hold_off_req <= 1'b1;
      sent = 0;
      while (sent < RANDOM_ITEMS_PER_PHASE) begin
        random_sequence(n);
        sent += n;
      end
    end

    // full store: a 1024 symbol palindrome, then symbols that overflow, last on one of them
    configure(HASH_W'($urandom_range(1, 24'hFFFFFF)), HASH_W'($urandom_range(2, 24'hFFFFFF)));
    no_idle <= 1'b0;
    for (int i = 0; i < MAX_LEN / 2; i++) long_run.push_back(pick_symbol(1'b0));
    for (int i = MAX_LEN / 2 - 1; i >= 0; i--) long_run.push_back(long_run[i]);
    repeat (6) long_run.push_back(pick_symbol(1'b0));
    foreach (long_run[i]) send_symbol(long_run[i], i == long_run.size() - 1);
    // the store starts afresh after the overflowing sequence
    random_sequence(n);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result sink: random ready, one long hold-off on request
  initial begin : result_sink
    bit hold_taken;
    int gap;
    hold_taken = 1'b0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      gap = idle_gap();
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // watchdog: ends the run after too many cycles without any transfer
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/epp_pkg.sv
rtl/epp_ifs.sv
rtl/epp_modunit.sv
rtl/epp_store.sv
rtl/even_palindrome_prefix_detect.sv
bench/epp_checker.sv
bench/testbench.sv
